FILE: hdl/hcbd_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hcbd_pkg
// Types, codes and helpers shared by the chunked body decoder modules.
// ----------------------------------------------------------------------------
package hcbd_pkg;

    localparam logic [7:0] CH_CR = 8'h0D;
    localparam logic [7:0] CH_LF = 8'h0A;

    typedef enum logic [2:0] {
        PH_DIGITS   = 3'd0,
        PH_EXT      = 3'd1,
        PH_SIZE_CR  = 3'd2,
        PH_DATA     = 3'd3,
        PH_TRAIL_CR = 3'd4,
        PH_TRAIL_LF = 3'd5,
        PH_DONE     = 3'd6
    } phase_t;

    typedef enum logic [1:0] {
        ST_RUN      = 2'd0,
        ST_OK       = 2'd1,
        ST_BAD_CRLF = 2'd2,
        ST_OVERFLOW = 2'd3
    } status_t;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       start_body;
    } in_item_t;

    typedef struct packed {
        logic        payload_valid;
        logic [7:0]  payload_byte;
        logic [1:0]  status;
        logic [31:0] body_length;
    } out_item_t;

    typedef struct packed {
        logic       is_hex;
        logic [3:0] value;
    } hex_digit_t;

    function automatic hex_digit_t hex_decode(input logic [7:0] c);
        hex_digit_t r;
        r.is_hex = 1'b1;
        r.value  = 4'd0;
        if (c inside {[8'h30:8'h39]}) begin
            r.value = c[3:0];
        end else if (c inside {[8'h41:8'h46], [8'h61:8'h66]}) begin
            r.value = c[3:0] + 4'd9;
        end else begin
            r.is_hex = 1'b0;
        end
        return r;
    endfunction

endpackage

FILE: hdl/http_chunked_body_decoder_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// http_chunked_body_decoder_top
// HTTP/1.1 chunked body decoder, one raw byte in and one result out per beat.
// ----------------------------------------------------------------------------
// Raw body bytes arrive on the byte channel (byte_valid, byte_stall,
// byte_beat). Each accepted beat produces exactly one result beat on the
// result channel (result_valid, result_stall, result_beat) carrying the
// decoded payload byte when there is one, the end status and the running
// body length.
// Results go into the result register, or into the skid entry while the
// receiver stalls. Throughput is one byte per cycle while byte_stall is
// low, set by the decoder state update between byte and result register.
// Reset clears the decoder to size-line reading, status in progress and a
// zero length, and empties the result register.
// When the receiver stalls, the result holds and one more byte is taken
// into a skid entry; byte_stall then rises until the receiver drains it.
// start_body on a beat re-arms the decoder before that byte is decoded.
// ----------------------------------------------------------------------------
module http_chunked_body_decoder_top #(
    parameter int SIZE_BITS = 32
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                byte_valid,
    output logic                byte_stall,
    input  hcbd_pkg::in_item_t  byte_beat,
    output logic                result_valid,
    input  logic                result_stall,
    output hcbd_pkg::out_item_t result_beat
);
    import hcbd_pkg::*;

    logic      fire;
    logic      full;
    out_item_t step_result;

    assign byte_stall = full;
    assign fire       = byte_valid && !full;

    hcbd_step #(
        .SIZE_BITS(SIZE_BITS)
    ) u_step (
        .clk    (clk),
        .rst_n  (rst_n),
        .fire   (fire),
        .item   (byte_beat),
        .result (step_result)
    );

    hcbd_skid u_skid (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (fire),
        .push_item (step_result),
        .full      (full),
        .valid     (result_valid),
        .stall     (result_stall),
        .beat      (result_beat)
    );

    a_stall_needs_result: assert property (@(posedge clk) disable iff (!rst_n)
        byte_stall |-> result_valid)
        else $error("byte_stall without a held result");

    a_payload_only_running: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && result_beat.payload_valid |-> result_beat.status == ST_RUN)
        else $error("payload beat after end of body");

    a_idle_byte_zero: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && !result_beat.payload_valid |-> result_beat.payload_byte == 8'd0)
        else $error("nonzero payload byte on non-payload beat");

endmodule

FILE: hdl/hcbd_step.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hcbd_step
// State registers and per-byte update, one beat per cycle while fire is high.
// ----------------------------------------------------------------------------
module hcbd_step #(
    parameter int SIZE_BITS = 32
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              fire,
    input  hcbd_pkg::in_item_t  item,
    output hcbd_pkg::out_item_t result
);
    import hcbd_pkg::*;

    phase_t                 phase_reg, phase_next;
    logic [SIZE_BITS-1:0]   size_reg, size_next;
    logic [SIZE_BITS-1:0]   done_reg, done_next;
    logic [31:0]            total_reg, total_next;
    status_t                code_reg, code_next;

    phase_t                 phase_cur;
    logic [SIZE_BITS-1:0]   size_cur;
    logic [SIZE_BITS-1:0]   done_cur;
    logic [SIZE_BITS-1:0]   done_inc;
    logic [31:0]            total_cur;
    status_t                code_cur;
    hex_digit_t             hd;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= PH_DIGITS;
            size_reg  <= '0;
            done_reg  <= '0;
            total_reg <= '0;
            code_reg  <= ST_RUN;
        end
        else if (fire)
        begin
            phase_reg <= phase_next;
            size_reg  <= size_next;
            done_reg  <= done_next;
            total_reg <= total_next;
            code_reg  <= code_next;
        end
    end

    always_comb
    begin
        // start flag re-arms before the byte is handled
        if (item.start_body)
        begin
            phase_cur = PH_DIGITS;
            size_cur  = '0;
            done_cur  = '0;
            total_cur = '0;
            code_cur  = ST_RUN;
        end
        else
        begin
            phase_cur = phase_reg;
            size_cur  = size_reg;
            done_cur  = done_reg;
            total_cur = total_reg;
            code_cur  = code_reg;
        end

        hd         = hex_decode(item.data_byte);
        done_inc   = done_cur + SIZE_BITS'(1);
        phase_next = phase_cur;
        size_next  = size_cur;
        done_next  = done_cur;
        total_next = total_cur;
        code_next  = code_cur;
        result.payload_valid = 1'b0;
        result.payload_byte  = 8'd0;

        case (phase_cur)
            PH_DIGITS:
            begin
                if (hd.is_hex)
                begin
                    if (size_cur[SIZE_BITS-1 -: 4] != 4'd0)
                    begin
                        phase_next = PH_DONE;
                        code_next  = ST_OVERFLOW;
                    end
                    else
                    begin
                        size_next = {size_cur[SIZE_BITS-5:0], hd.value};
                    end
                end
                else if (item.data_byte == CH_CR)
                begin
                    phase_next = PH_SIZE_CR;
                end
                else
                begin
                    phase_next = PH_EXT;
                end
            end
            PH_EXT:
            begin
                if (item.data_byte == CH_CR)
                begin
                    phase_next = PH_SIZE_CR;
                end
            end
            PH_SIZE_CR:
            begin
                if (item.data_byte == CH_LF)
                begin
                    if (size_cur == '0)
                    begin
                        phase_next = PH_DONE;
                        code_next  = ST_OK;
                    end
                    else
                    begin
                        done_next  = '0;
                        phase_next = PH_DATA;
                    end
                end
                else if (item.data_byte != CH_CR)
                begin
                    phase_next = PH_EXT;
                end
            end
            PH_DATA:
            begin
                result.payload_valid = 1'b1;
                result.payload_byte  = item.data_byte;
                if (total_cur != 32'hFFFF_FFFF)
                begin
                    total_next = total_cur + 32'd1;
                end
                done_next = done_inc;
                if (done_inc >= size_cur)
                begin
                    phase_next = PH_TRAIL_CR;
                end
            end
            PH_TRAIL_CR:
            begin
                if (item.data_byte == CH_CR)
                begin
                    phase_next = PH_TRAIL_LF;
                end
                else
                begin
                    phase_next = PH_DONE;
                    code_next  = ST_BAD_CRLF;
                end
            end
            PH_TRAIL_LF:
            begin
                if (item.data_byte == CH_LF)
                begin
                    size_next  = '0;
                    phase_next = PH_DIGITS;
                end
                else
                begin
                    phase_next = PH_DONE;
                    code_next  = ST_BAD_CRLF;
                end
            end
            default:
            begin
                phase_next = phase_cur;
            end
        endcase

        result.status      = code_next;
        result.body_length = total_next;
    end

endmodule

FILE: hdl/hcbd_skid.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hcbd_skid
// Result register with a skid entry; upstream stall comes from a flop.
// ----------------------------------------------------------------------------
module hcbd_skid (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                push,
    input  hcbd_pkg::out_item_t push_item,
    output logic                full,
    output logic                valid,
    input  logic                stall,
    output hcbd_pkg::out_item_t beat
);
    import hcbd_pkg::*;

    logic      main_valid_reg, main_valid_next;
    logic      skid_valid_reg, skid_valid_next;
    out_item_t main_reg, main_next;
    out_item_t skid_reg, skid_next;
    logic      pop;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            main_valid_reg <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else
        begin
            main_valid_reg <= main_valid_next;
            skid_valid_reg <= skid_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        main_reg <= main_next;
        skid_reg <= skid_next;
    end

    always_comb
    begin
        pop             = main_valid_reg && !stall;
        main_valid_next = main_valid_reg;
        skid_valid_next = skid_valid_reg;
        main_next       = main_reg;
        skid_next       = skid_reg;
        if (pop || !main_valid_reg)
        begin
            if (skid_valid_reg)
            begin
                main_next       = skid_reg;
                main_valid_next = 1'b1;
                skid_valid_next = 1'b0;
            end
            else
            begin
                main_next       = push_item;
                main_valid_next = push;
            end
        end
        else if (push)
        begin
            skid_next       = push_item;
            skid_valid_next = 1'b1;
        end
    end

    assign full  = skid_valid_reg;
    assign valid = main_valid_reg;
    assign beat  = main_reg;

endmodule
